// File: rtl/crc8pf_pkg.sv
// ----------------------------------------------------------------------------
// crc8pf_pkg
// Shared types, constants and the CRC-8 byte update for the packet framer.
// ----------------------------------------------------------------------------
package crc8pf_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned NibWidth   = 4;
  localparam int unsigned IdxWidth   = 8;

  // Configuration register indexes
  localparam logic [IdxWidth-1:0] REG_VERSION  = 8'd0;
  localparam logic [IdxWidth-1:0] REG_RESERVED = 8'd1;

  localparam logic [NibWidth-1:0] VERSION_RESET  = 4'h1;
  localparam logic [NibWidth-1:0] RESERVED_RESET = 4'hF;

  localparam logic [ByteWidth-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [ByteWidth-1:0] CRC_POLY_REF = 8'h8C;
  localparam logic [ByteWidth-1:0] CRC_INIT     = 8'h00;

  // Position of the byte being sent within a frame
  typedef enum logic [2:0] {
    POS_HDR = 3'd0,
    POS_LO  = 3'd1,
    POS_HI  = 3'd2,
    POS_CRC = 3'd3,
    POS_NL  = 3'd4
  } pos_t;

  // Header nibbles as held by the configuration registers
  typedef struct packed {
    logic [NibWidth-1:0] reserved_nib;
    logic [NibWidth-1:0] version_nib;
  } header_t;

  // One frame to send: the captured header and the number
  typedef struct packed {
    header_t               header;
    logic [ValueWidth-1:0] value;
  } item_t;

  // Status of the input holding stage as seen by the serializer
  typedef struct packed {
    logic valid;
  } hold_ctl_t;

  // Reflected CRC-8 (Maxim/Dallas) update over one byte
  function automatic logic [ByteWidth-1:0] crc8_update(
    input logic [ByteWidth-1:0] crc,
    input logic [ByteWidth-1:0] data
  );
    logic [ByteWidth-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < ByteWidth; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REF;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/crc8pf_cfg.sv
// ----------------------------------------------------------------------------
// crc8pf_cfg
// Configuration registers holding the two header nibbles.
// ----------------------------------------------------------------------------
module crc8pf_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crc8pf_pkg::IdxWidth-1:0]     cfg_index,
  input  logic [crc8pf_pkg::NibWidth-1:0]     cfg_data,
  output crc8pf_pkg::header_t                 header
);

  crc8pf_pkg::header_t hdr;

  assign cfg_ready = 1'b1;
  assign header    = hdr;

  // Drop writes to indexes outside the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr.version_nib  <= crc8pf_pkg::VERSION_RESET;
      hdr.reserved_nib <= crc8pf_pkg::RESERVED_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == crc8pf_pkg::REG_VERSION) begin
        hdr.version_nib <= cfg_data;
      end else if (cfg_index == crc8pf_pkg::REG_RESERVED) begin
        hdr.reserved_nib <= cfg_data;
      end
    end
  end

endmodule

// File: rtl/crc8pf_inreg.sv
// ----------------------------------------------------------------------------
// crc8pf_inreg
// Input holding register: captures one number with its header.
// ----------------------------------------------------------------------------
module crc8pf_inreg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [crc8pf_pkg::ValueWidth-1:0]    value,
  input  crc8pf_pkg::header_t                  header,
  input  logic                                 take,
  output crc8pf_pkg::hold_ctl_t                ctl,
  output crc8pf_pkg::item_t                    item
);

  logic              hold_valid;
  crc8pf_pkg::item_t hold_item;

  // Accept when empty, or when the held item moves on this cycle
  assign in_ready  = !hold_valid || take;
  assign ctl.valid = hold_valid;
  assign item      = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item.value  <= value;
      hold_item.header <= header;
    end
  end

endmodule

// File: rtl/crc8pf_ser.sv
// ----------------------------------------------------------------------------
// crc8pf_ser
// Frame serializer: walks the five bytes, folds the CRC one byte per cycle
// while the output register is free, and drives the output register.
// ----------------------------------------------------------------------------
module crc8pf_ser (
  input  logic                                clk,
  input  logic                                rst,
  input  crc8pf_pkg::hold_ctl_t               ctl,
  input  crc8pf_pkg::item_t                   item,
  output logic                                take,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [crc8pf_pkg::ByteWidth-1:0]    frame_byte,
  output logic                                last_byte
);

  logic                             active;
  crc8pf_pkg::pos_t                 pos;
  crc8pf_pkg::pos_t                 pos_next;
  crc8pf_pkg::item_t                frame;
  logic [crc8pf_pkg::ByteWidth-1:0] crc;
  logic [crc8pf_pkg::ByteWidth-1:0] crc_next;
  logic [crc8pf_pkg::ByteWidth-1:0] byte_sel;
  logic                             out_free;
  logic                             advance;
  logic                             at_end;

  assign out_free = !out_valid || out_ready;
  assign advance  = active && out_free;
  assign at_end   = (pos == crc8pf_pkg::POS_NL);
  assign take     = ctl.valid && (!active || (advance && at_end));

  always_comb begin
    case (pos)
      crc8pf_pkg::POS_HDR: byte_sel = frame.header;
      crc8pf_pkg::POS_LO:  byte_sel = frame.value[7:0];
      crc8pf_pkg::POS_HI:  byte_sel = frame.value[15:8];
      crc8pf_pkg::POS_CRC: byte_sel = crc;
      default:             byte_sel = crc8pf_pkg::NEWLINE_BYTE;
    endcase
  end

  always_comb begin
    case (pos)
      crc8pf_pkg::POS_HDR: pos_next = crc8pf_pkg::POS_LO;
      crc8pf_pkg::POS_LO:  pos_next = crc8pf_pkg::POS_HI;
      crc8pf_pkg::POS_HI:  pos_next = crc8pf_pkg::POS_CRC;
      crc8pf_pkg::POS_CRC: pos_next = crc8pf_pkg::POS_NL;
      default:             pos_next = crc8pf_pkg::POS_HDR;
    endcase
  end

  assign crc_next = crc8pf_pkg::crc8_update(crc, byte_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos    <= crc8pf_pkg::POS_HDR;
    end else if (take) begin
      active <= 1'b1;
      pos    <= crc8pf_pkg::POS_HDR;
    end else if (advance) begin
      active <= !at_end;
      pos    <= pos_next;
    end
  end

  // Fold the CRC only over header and number bytes
  always_ff @(posedge clk) begin
    if (take) begin
      frame <= item;
      crc   <= crc8pf_pkg::CRC_INIT;
    end else if (advance && (pos == crc8pf_pkg::POS_HDR || pos == crc8pf_pkg::POS_LO ||
                             pos == crc8pf_pkg::POS_HI)) begin
      crc <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_byte <= byte_sel;
      last_byte  <= at_end;
    end
  end

endmodule

// File: rtl/crc8_packet_framer_core.sv
// ----------------------------------------------------------------------------
// crc8_packet_framer_core
// Frames a signed 16-bit number into header, two data bytes, CRC-8, newline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/value) takes one number per transaction.
//   Output channel (out_valid/out_ready/frame_byte/last_byte) gives five
//   transactions per number in send order: header (version nibble low,
//   reserved nibble high), value low byte, value high byte, CRC-8
//   (Maxim/Dallas, reflected 0x8C, init 0) over the first three bytes, and
//   a newline with last_byte set.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes register
//   0 (version nibble) or 1 (reserved nibble); cfg_ready is always high and
//   other indexes are dropped. Write only while no frame is in flight.
// Timing:
//   A number passes through the input register, the serializer's frame
//   register and the output register; frame bytes follow one per cycle
//   while out_ready is high; the next number waits in the input register
//   as a frame drains. The CRC is folded one byte per cycle as bytes go out.
// Reset and stalls:
//   rst clears all valid flags and loads version 1 and reserved 15.
//   When out_ready is low the output register holds its byte, the serializer
//   stops, and one more number is still taken into the input register.
// ----------------------------------------------------------------------------
module crc8_packet_framer_core (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [crc8pf_pkg::ValueWidth-1:0] value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [crc8pf_pkg::ByteWidth-1:0]        frame_byte,
  output logic                                    last_byte,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [crc8pf_pkg::IdxWidth-1:0]         cfg_index,
  input  logic [crc8pf_pkg::NibWidth-1:0]         cfg_data
);

  crc8pf_pkg::header_t   header;
  crc8pf_pkg::hold_ctl_t hold_ctl;
  crc8pf_pkg::item_t     hold_item;
  logic                  take;

  // Header nibbles; captured with each number so a frame is self-contained
  crc8pf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .header    (header)
  );

  // Hold the next number while the current frame drains
  crc8pf_inreg u_inreg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .header   (header),
    .take     (take),
    .ctl      (hold_ctl),
    .item     (hold_item)
  );

  // Advance through the frame one byte per free output slot
  crc8pf_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .ctl        (hold_ctl),
    .item       (hold_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

endmodule

// File: rtl/crc8pf_checker.sv
// ----------------------------------------------------------------------------
// crc8pf_checker
// Port-level checks for the packet framer, bound to the top level.
// ----------------------------------------------------------------------------
module crc8pf_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     out_valid,
  input logic                                     out_ready,
  input logic [crc8pf_pkg::ByteWidth-1:0]         frame_byte,
  input logic                                     last_byte,
  input logic                                     cfg_valid,
  input logic                                     cfg_ready
);

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last_byte))
    else $error("output transaction changed while stalled");

  // The closing byte is always the newline
  a_last_nl: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> frame_byte == crc8pf_pkg::NEWLINE_BYTE)
    else $error("last byte is not a newline");

  // A newline byte sent leaves no further last flag in the next cycle
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_byte |=> !(out_valid && last_byte))
    else $error("two frame ends back to back");

  // Nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // Config port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config port stalled");

endmodule

bind crc8_packet_framer_core crc8pf_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .frame_byte (frame_byte),
  .last_byte  (last_byte),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

// File: tb/crc8pf_frame_checker.sv
// ----------------------------------------------------------------------------
// crc8pf_frame_checker
// Watches the framer's channels, builds the expected five-byte frame for
// every accepted number and compares each output transaction against it.
// ----------------------------------------------------------------------------
module crc8pf_frame_checker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  input  logic                                     in_ready,
  input  logic signed [crc8pf_pkg::ValueWidth-1:0] value,
  input  logic                                     out_valid,
  input  logic                                     out_ready,
  input  logic [crc8pf_pkg::ByteWidth-1:0]         frame_byte,
  input  logic                                     last_byte,
  input  logic                                     cfg_valid,
  input  logic                                     cfg_ready,
  input  logic [crc8pf_pkg::IdxWidth-1:0]          cfg_index,
  input  logic [crc8pf_pkg::NibWidth-1:0]          cfg_data,
  output int                                       bytes_outstanding,
  output int                                       mismatch_count
);

  localparam int FrameBytes = 5;

  typedef struct packed {
    logic [crc8pf_pkg::ByteWidth-1:0] data;
    logic                             last;
  } frame_beat_t;

  crc8pf_pkg::header_t hdr_regs;
  frame_beat_t         frame_bytes_due[$];

  // Bit-serial form of the reflected CRC-8: shift data in LSB first.
  function automatic logic [crc8pf_pkg::ByteWidth-1:0] crc8_fold(
    input logic [crc8pf_pkg::ByteWidth-1:0] crc,
    input logic [crc8pf_pkg::ByteWidth-1:0] data
  );
    logic [crc8pf_pkg::ByteWidth-1:0] acc;
    logic                             fb;
    acc = crc;
    for (int i = 0; i < crc8pf_pkg::ByteWidth; i++) begin
      fb  = acc[0] ^ data[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ crc8pf_pkg::CRC_POLY_REF;
      end
    end
    return acc;
  endfunction

  function automatic void queue_frame(input logic [crc8pf_pkg::ValueWidth-1:0] number);
    logic [crc8pf_pkg::ByteWidth-1:0] hdr_byte;
    logic [crc8pf_pkg::ByteWidth-1:0] lo_byte;
    logic [crc8pf_pkg::ByteWidth-1:0] hi_byte;
    logic [crc8pf_pkg::ByteWidth-1:0] crc;
    hdr_byte = {hdr_regs.reserved_nib, hdr_regs.version_nib};
    lo_byte  = number[7:0];
    hi_byte  = number[15:8];
    crc      = crc8_fold(crc8pf_pkg::CRC_INIT, hdr_byte);
    crc      = crc8_fold(crc, lo_byte);
    crc      = crc8_fold(crc, hi_byte);
    frame_bytes_due.push_back('{hdr_byte, 1'b0});
    frame_bytes_due.push_back('{lo_byte, 1'b0});
    frame_bytes_due.push_back('{hi_byte, 1'b0});
    frame_bytes_due.push_back('{crc, 1'b0});
    frame_bytes_due.push_back('{crc8pf_pkg::NEWLINE_BYTE, 1'b1});
  endfunction

  always @(posedge clk) begin
    frame_beat_t due;
    if (rst) begin
      hdr_regs.version_nib  = crc8pf_pkg::VERSION_RESET;
      hdr_regs.reserved_nib = crc8pf_pkg::RESERVED_RESET;
      frame_bytes_due.delete();
      bytes_outstanding <= 0;
      mismatch_count    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          crc8pf_pkg::REG_VERSION:  hdr_regs.version_nib  = cfg_data;
          crc8pf_pkg::REG_RESERVED: hdr_regs.reserved_nib = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (frame_bytes_due.size() == 0) begin
          $error("frame_byte %02h (last_byte %0b) with no frame pending",
                 frame_byte, last_byte);
          mismatch_count = mismatch_count + 1;
        end else begin
          due = frame_bytes_due.pop_front();
          if (frame_byte !== due.data) begin
            $error("frame_byte: expected %02h, actual %02h", due.data, frame_byte);
            mismatch_count = mismatch_count + 1;
          end
          if (last_byte !== due.last) begin
            $error("last_byte: expected %0b, actual %0b", due.last, last_byte);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        queue_frame(value);
      end
      bytes_outstanding <= bytes_outstanding + ((in_valid && in_ready) ? FrameBytes : 0)
                           - ((out_valid && out_ready) ? 1 : 0);
    end
  end

endmodule

// File: tb/crc8_packet_framer_core_test.sv
// ----------------------------------------------------------------------------
// crc8_packet_framer_core_test
// Drives numbers and header settings into the framer with random pacing on
// both channels; a checker beside the block predicts every frame byte.
// ----------------------------------------------------------------------------
module crc8_packet_framer_core_test;

  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 11;
  localparam int SettleCycles  = 4;     // lets the pipeline go quiet after draining
  localparam int WatchdogLimit = 1000;  // cycles without any transaction
  localparam int RandomPhases  = 6;
  localparam int ItemsPerPhase = 17;

  // Register indexes past the last real register; writes there are dropped
  localparam logic [crc8pf_pkg::IdxWidth-1:0] IDX_UNUSED_LOW  =
    crc8pf_pkg::REG_RESERVED + 8'd1;
  localparam logic [crc8pf_pkg::IdxWidth-1:0] IDX_UNUSED_MID  = 8'h80;
  localparam logic [crc8pf_pkg::IdxWidth-1:0] IDX_UNUSED_HIGH = 8'hFF;

  logic clk = 1'b0;
  logic rst;

  logic                                     in_valid;
  logic                                     in_ready;
  logic signed [crc8pf_pkg::ValueWidth-1:0] value;
  logic                                     out_valid;
  logic                                     out_ready;
  logic [crc8pf_pkg::ByteWidth-1:0]         frame_byte;
  logic                                     last_byte;
  logic                                     cfg_valid;
  logic                                     cfg_ready;
  logic [crc8pf_pkg::IdxWidth-1:0]          cfg_index;
  logic [crc8pf_pkg::NibWidth-1:0]          cfg_data;

  int bytes_outstanding;
  int mismatch_count;
  int idle_cycles;
  bit steady_pacing;  // when set, neither side inserts gaps

  always #(ClkPeriod / 2) clk = ~clk;

  crc8_packet_framer_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  crc8pf_frame_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .value             (value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .frame_byte        (frame_byte),
    .last_byte         (last_byte),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .bytes_outstanding (bytes_outstanding),
    .mismatch_count    (mismatch_count)
  );

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_pacing || roll < 45) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  // Random number, biased toward the corners of the 16-bit range.
  function automatic logic [crc8pf_pkg::ValueWidth-1:0] pick_value();
    logic [crc8pf_pkg::ValueWidth-1:0] one_hot;
    one_hot = 16'h0001 << $urandom_range(0, crc8pf_pkg::ValueWidth - 1);
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Hold valid and the number until the transaction is taken. Keep valid high
  // across back-to-back numbers so it never drops and rises in one step.
  task automatic send_value(input logic [crc8pf_pkg::ValueWidth-1:0] number);
    int unsigned gap_len;
    gap_len = pick_gap();
    if (gap_len > 0) begin
      in_valid <= 1'b0;
      repeat (gap_len) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= number;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every predicted byte has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_outstanding != 0);
  endtask

  // Drain, then let the pipeline go quiet before touching the registers.
  task automatic settle();
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Leave cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [crc8pf_pkg::IdxWidth-1:0] idx,
                           input logic [crc8pf_pkg::NibWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Leave cfg_valid high; the caller drops it after the last write.
  task automatic set_header(input logic [crc8pf_pkg::NibWidth-1:0] version_nib,
                            input logic [crc8pf_pkg::NibWidth-1:0] reserved_nib);
    settle();
    write_reg(crc8pf_pkg::REG_VERSION, version_nib);
    write_reg(crc8pf_pkg::REG_RESERVED, reserved_nib);
  endtask

  // Output side: alternate ready runs with stalls of random length.
  initial begin : sink_pacing
    int unsigned run_len;
    int unsigned gap_len;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      run_len = $urandom_range(1, 12);
      repeat (run_len) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
      gap_len = pick_gap();
      repeat (gap_len) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("crc8_packet_framer_core regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [crc8pf_pkg::NibWidth-1:0] version_nib;
    logic [crc8pf_pkg::NibWidth-1:0] reserved_nib;
    steady_pacing = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    value     <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= crc8pf_pkg::REG_VERSION;
    cfg_data  <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset header: all-zero, all-one, sign edges and byte-boundary patterns.
    send_value(16'h0000);
    send_value(16'h0001);
    send_value(16'hFFFF);
    send_value(16'h7FFF);
    send_value(16'h8000);
    send_value(16'h5555);
    send_value(16'hAAAA);
    send_value(16'h00FF);
    send_value(16'hFF00);
    send_value(16'h0080);

    // Zero header; writes to unused indexes must not disturb it.
    set_header(4'h0, 4'h0);
    write_reg(IDX_UNUSED_LOW, 4'hF);
    write_reg(IDX_UNUSED_HIGH, 4'hF);
    cfg_valid <= 1'b0;
    send_value(16'h1234);
    send_value(16'hFFFF);

    // Full header, back to back with no gaps.
    steady_pacing = 1'b1;
    set_header(4'hF, 4'hF);
    cfg_valid <= 1'b0;
    send_value(16'h0000);
    send_value(16'h8000);
    send_value(16'h7FFF);
    steady_pacing = 1'b0;

    // Mixed nibbles, one more dropped write.
    set_header(4'h0, 4'hF);
    write_reg(IDX_UNUSED_MID, 4'h0);
    cfg_valid <= 1'b0;
    send_value(16'h0007);
    send_value(16'hFFFE);
    set_header(4'hF, 4'h0);
    cfg_valid <= 1'b0;
    send_value(16'h4321);

    // Random phases: new header each time, some steady, some idling.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      version_nib  = 4'($urandom_range(0, 15));
      reserved_nib = 4'($urandom_range(0, 15));
      steady_pacing = (phase % 3 == 1);
      set_header(version_nib, reserved_nib);
      if ($urandom_range(0, 1) == 1) begin
        write_reg(8'($urandom_range(IDX_UNUSED_LOW, IDX_UNUSED_HIGH)),
                  4'($urandom_range(0, 15)));
      end
      cfg_valid <= 1'b0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Hold off the sender until the block has emptied, once for sure.
        if ((phase == 0 && n == ItemsPerPhase / 2) || $urandom_range(0, 19) == 0) begin
          wait_drained();
        end
        send_value(pick_value());
      end
    end

    settle();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0 && bytes_outstanding == 0) begin
      $display("crc8_packet_framer_core regression: pass");
    end else begin
      $display("crc8_packet_framer_core regression: fail");
    end
    $finish;
  end

endmodule
